// ===== sv/sec_pkg.sv =====
// Shared types and constants of the Sobel edge pixel counter.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package sec_pkg;

	localparam int PIX_W     = 8;
	localparam int COUNT_W   = 22;
	localparam int TALLY_W   = 23;
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 13;
	localparam int THR_W     = 8;
	localparam int THR_SQ_W  = 2 * THR_W;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;

	// register indexes (byte address = 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

	localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH    = 11'd640;
	localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;
	localparam logic [THR_W-1:0]    RST_EDGE_THRESHOLD = 8'd70;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [WIDTH_W-1:0]  image_width;
		logic [HEIGHT_W-1:0] image_height;
		logic [THR_SQ_W-1:0] thr_sq;
	} cfg_t;

	// per-pixel control that travels down the pipe
	typedef struct packed {
		logic interior;
		logic frame_end;
	} tag_t;

endpackage

`default_nettype wire

// ===== sv/sec_cfg_regs.sv =====
// APB register file: image width, image height, edge threshold.
// Keeps the squared threshold ready for the compare. Uses sec_pkg.
`default_nettype none

module sec_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sec_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [sec_pkg::PDATA_W-1:0]   pwdata,
	output      logic [sec_pkg::PDATA_W-1:0]   prdata,
	output      logic                          pready,
	output      sec_pkg::cfg_t                 cfg
);

	logic [sec_pkg::WIDTH_W-1:0]  image_width_q;
	logic [sec_pkg::HEIGHT_W-1:0] image_height_q;
	logic [sec_pkg::THR_W-1:0]    thr_q;
	logic [sec_pkg::THR_SQ_W-1:0] thr_sq_q;
	logic [sec_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;
	logic [sec_pkg::THR_W-1:0]    thr_new;

	assign pready  = 1'b1;
	assign reg_idx = paddr[sec_pkg::PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign thr_new = pwdata[sec_pkg::THR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= sec_pkg::RST_IMAGE_WIDTH;
			image_height_q <= sec_pkg::RST_IMAGE_HEIGHT;
			thr_q          <= sec_pkg::RST_EDGE_THRESHOLD;
			thr_sq_q       <= sec_pkg::THR_SQ_W'(sec_pkg::RST_EDGE_THRESHOLD) *
			                  sec_pkg::THR_SQ_W'(sec_pkg::RST_EDGE_THRESHOLD);
		end else if (wr_en) begin
			unique case (reg_idx)
				sec_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= pwdata[sec_pkg::WIDTH_W-1:0];
				end
				sec_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= pwdata[sec_pkg::HEIGHT_W-1:0];
				end
				sec_pkg::REG_EDGE_THRESHOLD: begin
					thr_q    <= thr_new;
					thr_sq_q <= sec_pkg::THR_SQ_W'(thr_new) * sec_pkg::THR_SQ_W'(thr_new);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			sec_pkg::REG_IMAGE_WIDTH:    prdata = sec_pkg::PDATA_W'(image_width_q);
			sec_pkg::REG_IMAGE_HEIGHT:   prdata = sec_pkg::PDATA_W'(image_height_q);
			sec_pkg::REG_EDGE_THRESHOLD: prdata = sec_pkg::PDATA_W'(thr_q);
			default:                     prdata = '0;
		endcase
	end

	assign cfg.image_width  = image_width_q;
	assign cfg.image_height = image_height_q;
	assign cfg.thr_sq       = thr_sq_q;

endmodule

`default_nettype wire

// ===== sv/sec_line_mem.sv =====
// Line store: one synchronous RAM, word = {row two above, row above}.
// One write and one read port, read data registered. Uses sec_pkg.
`default_nettype none

module sec_line_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [AW-1:0]                 rd_addr,
	output      logic [2*sec_pkg::PIX_W-1:0]   rd_data,
	input  wire logic                          wr_en,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [2*sec_pkg::PIX_W-1:0]   wr_data
);

	logic [2*sec_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/sec_grad_pipe.sv =====
// 3x3 window, Sobel gradients and the squared-norm edge test.
// Stages s2..s4 behind the line store read. Uses sec_pkg.
`default_nettype none

module sec_grad_pipe (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          vld_s1,
	input  wire sec_pkg::tag_t                 tag_s1,
	input  wire logic [sec_pkg::PIX_W-1:0]     top_s1,
	input  wire logic [sec_pkg::PIX_W-1:0]     mid_s1,
	input  wire logic [sec_pkg::PIX_W-1:0]     px_s1,
	input  wire logic [sec_pkg::THR_SQ_W-1:0]  thr_sq,
	output      logic                          vld_s4,
	output      sec_pkg::tag_t                 tag_s4,
	output      logic                          is_edge_s4
);

	localparam int SUM_W = sec_pkg::PIX_W + 2;
	localparam int SQ_W  = 2 * sec_pkg::PIX_W;

	// win_q[row*3+col], col 2 newest, row 2 bottom
	logic [sec_pkg::PIX_W-1:0] win_q [9];

	logic                      vld_s2, vld_s3;
	sec_pkg::tag_t             tag_s2, tag_s3;
	logic [sec_pkg::PIX_W-1:0] ax_s3, ay_s3;
	logic [SQ_W-1:0]           sqx_s4, sqy_s4;

	logic [SUM_W-1:0] xp, xn, yp, yn, xabs, yabs;
	logic [sec_pkg::PIX_W-1:0] ax, ay;
	logic [SQ_W:0]    norm_sq;

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv && vld_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3+0] <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= top_s1;
			win_q[5] <= mid_s1;
			win_q[8] <= px_s1;
		end
	end

	// s2: mask sums, |g|/2 clamped to a byte
	always_comb begin
		xp = SUM_W'(win_q[2]) + {1'b0, win_q[5], 1'b0} + SUM_W'(win_q[8]);
		xn = SUM_W'(win_q[0]) + {1'b0, win_q[3], 1'b0} + SUM_W'(win_q[6]);
		yp = SUM_W'(win_q[6]) + {1'b0, win_q[7], 1'b0} + SUM_W'(win_q[8]);
		yn = SUM_W'(win_q[0]) + {1'b0, win_q[1], 1'b0} + SUM_W'(win_q[2]);
		xabs = (xp >= xn) ? (xp - xn) : (xn - xp);
		yabs = (yp >= yn) ? (yp - yn) : (yn - yp);
		// truncation toward zero of g/2 then abs equals |g| >> 1
		ax = xabs[SUM_W-1] ? '1 : xabs[sec_pkg::PIX_W:1];
		ay = yabs[SUM_W-1] ? '1 : yabs[sec_pkg::PIX_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			ax_s3  <= ax;
			ay_s3  <= ay;
			tag_s4 <= tag_s3;
			sqx_s4 <= SQ_W'(ax_s3) * SQ_W'(ax_s3);
			sqy_s4 <= SQ_W'(ay_s3) * SQ_W'(ay_s3);
		end
	end

	// s4: norm compare
	assign norm_sq    = (SQ_W+1)'(sqx_s4) + (SQ_W+1)'(sqy_s4);
	assign is_edge_s4 = norm_sq >= (SQ_W+1)'(thr_sq);

endmodule

`default_nettype wire

// ===== sv/sobel_edge_pixel_counter.sv =====
// Sobel edge pixel counter, top level: frame position, line store control,
// edge tally and result register. Uses sec_pkg, sec_cfg_regs, sec_line_mem,
// sec_grad_pipe.
//
//  port group          dir   width  contents
//  s_tvalid/tready     in     8     pixel, raster order
//  m_tvalid/tready     out   24     edge_count of the frame, once per frame
//  psel..prdata        APB   32     image_width @0, image_height @4,
//                                   edge_threshold @8
//
// One pixel per cycle sustained while the pipe advances. The line store RAM
// (one read, one write port) is read on the accept edge and written back
// when its pixel moves on from s1. The frame's count is loaded into the
// result register once its last pixel has passed the RAM read, window,
// gradients and squares/compare stages. Input stalls only when a frame count
// still waits in the result register and the next frame's last pixel reaches
// the tally stage. Reset clears control only; line store contents stay
// undefined, no clearing pass.
`default_nettype none

module sobel_edge_pixel_counter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// pixel stream in
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	input  wire logic [7:0]                    s_tdata,   // [7:0] pixel
	// edge count out
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	output      logic [23:0]                   m_tdata,   // [21:0] edge_count
	// register port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sec_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [sec_pkg::PDATA_W-1:0]   pwdata,
	output      logic [sec_pkg::PDATA_W-1:0]   prdata,
	output      logic                          pready
);

	localparam int CB   = $clog2(MAX_WIDTH);
	localparam int RB   = $clog2(MAX_HEIGHT);
	localparam int WLB  = $clog2(MAX_WIDTH + 1);
	localparam int HLB  = $clog2(MAX_HEIGHT + 1);
	localparam int WCMP = (WLB > sec_pkg::WIDTH_W) ? WLB : sec_pkg::WIDTH_W;
	localparam int HCMP = (HLB > sec_pkg::HEIGHT_W) ? HLB : sec_pkg::HEIGHT_W;

	sec_pkg::cfg_t cfg;

	sec_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// position of the next pixel
	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;

	// s1: pixel waiting for its line store read
	logic                      vld_s1;
	sec_pkg::tag_t             tag_s1;
	logic [sec_pkg::PIX_W-1:0] px_s1;
	logic [CB-1:0]             col_s1;

	logic [2*sec_pkg::PIX_W-1:0] rd_data;

	logic                      vld_s4;
	sec_pkg::tag_t             tag_s4;
	logic                      is_edge_s4;

	logic [sec_pkg::TALLY_W-1:0] tally_q;
	logic [sec_pkg::TALLY_W-1:0] tally_nxt;
	logic                        out_vld_q;
	logic [sec_pkg::COUNT_W-1:0] out_data_q;

	logic            adv;
	logic            accept;
	logic [WCMP-1:0] wid_ext, w_lim;
	logic [HCMP-1:0] hgt_ext, h_lim;
	logic            col_last, row_last;
	sec_pkg::tag_t   tag_in;

	// whole pipe moves together; only a frame count blocked at the
	// result register holds it
	assign adv      = !(vld_s4 && tag_s4.frame_end && out_vld_q && !m_tready);
	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;

	// frame size clamped to 3..MAX
	always_comb begin
		wid_ext = WCMP'(cfg.image_width);
		hgt_ext = HCMP'(cfg.image_height);
		priority if (wid_ext < WCMP'(3)) begin
			w_lim = WCMP'(3);
		end else if (wid_ext > WCMP'(MAX_WIDTH)) begin
			w_lim = WCMP'(MAX_WIDTH);
		end else begin
			w_lim = wid_ext;
		end
		priority if (hgt_ext < HCMP'(3)) begin
			h_lim = HCMP'(3);
		end else if (hgt_ext > HCMP'(MAX_HEIGHT)) begin
			h_lim = HCMP'(MAX_HEIGHT);
		end else begin
			h_lim = hgt_ext;
		end
	end

	assign col_last         = (WCMP'(col_q) + WCMP'(1)) >= w_lim;
	assign row_last         = (HCMP'(row_q) + HCMP'(1)) >= h_lim;
	assign tag_in.interior  = (row_q >= RB'(2)) && (col_q >= CB'(2));
	assign tag_in.frame_end = col_last && row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= accept;
			end
			if (accept) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + RB'(1);
				end else begin
					col_q <= col_q + CB'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1 <= tag_in;
			px_s1  <= s_tdata[sec_pkg::PIX_W-1:0];
			col_s1 <= col_q;
		end
	end

	// RAM word: [15:8] row two above, [7:0] row above. Back to back
	// pixels never share a column, so the write-back of s1 and the read
	// of the new pixel never hit the same entry.
	sec_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CB)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (adv && vld_s1),
		.wr_addr (col_s1),
		.wr_data ({rd_data[sec_pkg::PIX_W-1:0], px_s1})
	);

	sec_grad_pipe u_grad (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.vld_s1     (vld_s1),
		.tag_s1     (tag_s1),
		.top_s1     (rd_data[2*sec_pkg::PIX_W-1:sec_pkg::PIX_W]),
		.mid_s1     (rd_data[sec_pkg::PIX_W-1:0]),
		.px_s1      (px_s1),
		.thr_sq     (cfg.thr_sq),
		.vld_s4     (vld_s4),
		.tag_s4     (tag_s4),
		.is_edge_s4 (is_edge_s4)
	);

	// tally and result register
	assign tally_nxt = tally_q +
	                   sec_pkg::TALLY_W'(tag_s4.interior && is_edge_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (adv && vld_s4) begin
				if (tag_s4.frame_end) begin
					tally_q   <= '0;
					out_vld_q <= 1'b1;
				end else begin
					tally_q <= tally_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s4 && tag_s4.frame_end) begin
			out_data_q <= tally_nxt[sec_pkg::COUNT_W-1:0];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_data_q};

endmodule

`default_nettype wire

// ===== tb/sv/sobel_edge_pixel_counter_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sobel_edge_pixel_counter: gray frames in over the pixel stream,
// one edge count per frame out, each checked against a Sobel predictor held here.
// Depends on sec_pkg and the RTL of the block only.

module sobel_edge_pixel_counter_test;

	localparam int LINE_MAX        = 1024;
	localparam int ROWS_MAX        = 4096;
	localparam int DRAIN_CYCLES    = 12;	// margin for the result to leave after the last pixel
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PIXELS   = 1000;
	localparam int NO_TABLE_COUNT  = -1;
	localparam int RUN_LIMIT_NS    = 2_000_000;

	typedef enum int {FLOW_STEADY, FLOW_SRC_GAPS, FLOW_SNK_STALLS, FLOW_BOTH} flow_t;
	typedef enum int {PIX_TABLE, PIX_NOISE, PIX_SMOOTH, PIX_BINARY} pix_style_t;

	// directed frame: register values, flat body level, level of the last column,
	// and the count that follows at a glance
	typedef struct packed {
		logic [sec_pkg::WIDTH_W-1:0]  width;
		logic [sec_pkg::HEIGHT_W-1:0] height;
		logic [sec_pkg::THR_W-1:0]    thr;
		logic [sec_pkg::PIX_W-1:0]    body;
		logic [sec_pkg::PIX_W-1:0]    last_col;
		int                           count;
	} frame_row_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata  = '0;	// [7:0] pixel
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [23:0]                   m_tdata;	// [21:0] edge_count
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [sec_pkg::PADDR_W-1:0]   paddr    = '0;
	logic [sec_pkg::PDATA_W-1:0]   pwdata   = '0;
	logic [sec_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;

	sobel_edge_pixel_counter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor state: own copy of registers, line stores, window and
	// frame position. Line stores start at zero; entries read before
	// they are written only reach border pixels, so the start value is moot.
	// ---------------------------------------------------------------
	logic [sec_pkg::WIDTH_W-1:0]  cfg_width  = sec_pkg::RST_IMAGE_WIDTH;
	logic [sec_pkg::HEIGHT_W-1:0] cfg_height = sec_pkg::RST_IMAGE_HEIGHT;
	logic [sec_pkg::THR_W-1:0]    cfg_thr    = sec_pkg::RST_EDGE_THRESHOLD;
	logic [7:0]                   line_upper [LINE_MAX] = '{default: '0};
	logic [7:0]                   line_lower [LINE_MAX] = '{default: '0};
	logic [7:0]                   win [9] = '{default: '0};	// [row*3+col], col 2 newest
	logic [9:0]                   col_pos = '0;
	logic [11:0]                  row_pos = '0;
	logic [sec_pkg::TALLY_W-1:0]  tally   = '0;

	logic [sec_pkg::COUNT_W-1:0]  frame_counts_due [$];	// counts owed by the block, oldest first
	int                           table_counts [$];	// per frame: typed count or NO_TABLE_COUNT
	int                           mismatch_total = 0;
	flow_t                        flow = FLOW_STEADY;
	bit                           sink_held = 1'b0;
	event                         hold_off_start;

	// sizes out of range are pulled into 3..max when used
	function automatic int clamp_dim(input int v, input int hi);
		return (v < 3) ? 3 : (v > hi) ? hi : v;
	endfunction

	// mask sum halved toward zero, magnitude saturated to a byte
	function automatic int half_mag(input int s);
		int h;
		h = s / 2;
		if (h < 0) h = -h;
		return (h > 255) ? 255 : h;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] expv,
			input logic [31:0] actv);
		mismatch_total++;
		if (mismatch_total <= 10)
			$display("MISMATCH %s: expected %0d, got %0d", what, expv, actv);
	endtask

	// one accepted pixel through the window; owes a count on the frame's last pixel
	task automatic sobel_predict_pixel(input logic [7:0] px);
		int w, h, c, r, gx, gy, ax, ay, tc;
		logic [7:0] top, mid;
		w = clamp_dim(int'(cfg_width), LINE_MAX);
		h = clamp_dim(int'(cfg_height), ROWS_MAX);
		c = int'(col_pos);
		top = line_upper[c];
		mid = line_lower[c];
		for (r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = px;
		line_upper[c] = mid;
		line_lower[c] = px;

		// interior only: window needs two rows above and two columns to the left
		if (row_pos >= 2 && col_pos >= 2) begin
			gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
				- (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
			gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
				- (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
			ax = half_mag(gx);
			ay = half_mag(gy);
			if (ax * ax + ay * ay >= int'(cfg_thr) * int'(cfg_thr))
				tally = tally + 1'b1;
		end

		if (col_pos + 1 >= w) begin
			col_pos = '0;
			if (row_pos + 1 >= h) begin
				tc = (table_counts.size() != 0) ? table_counts.pop_front() : NO_TABLE_COUNT;
				if (tc == NO_TABLE_COUNT)
					frame_counts_due.push_back(tally[sec_pkg::COUNT_W-1:0]);
				else
					frame_counts_due.push_back(tc[sec_pkg::COUNT_W-1:0]);
				row_pos = '0;
				tally = '0;
			end else begin
				row_pos = row_pos + 1'b1;
			end
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	// pixel transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sobel_predict_pixel(s_tdata);
	end

	// register writes land in the predictor's copy
	always @(posedge clk) begin
		if (arst_n && psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				sec_pkg::REG_IMAGE_WIDTH:    cfg_width  = pwdata[sec_pkg::WIDTH_W-1:0];
				sec_pkg::REG_IMAGE_HEIGHT:   cfg_height = pwdata[sec_pkg::HEIGHT_W-1:0];
				sec_pkg::REG_EDGE_THRESHOLD: cfg_thr    = pwdata[sec_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// count transfers against the oldest owed count
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_counts_due.size() == 0)
				flag_mismatch("edge count with nothing due", '0,
					m_tdata[sec_pkg::COUNT_W-1:0]);
			else if (m_tdata[sec_pkg::COUNT_W-1:0] !== frame_counts_due[0]) begin
				flag_mismatch("edge_count", frame_counts_due[0],
					m_tdata[sec_pkg::COUNT_W-1:0]);
				void'(frame_counts_due.pop_front());
			end else begin
				void'(frame_counts_due.pop_front());
			end
		end
	end

	// receiver: random stalls by flow mode, or held off entirely while sink_held
	always @(posedge clk) begin
		if (sink_held)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >=
				((flow == FLOW_SNK_STALLS) ? 51 : (flow == FLOW_BOTH) ? 7 : 0));
	end

	// long hold-off, counted here, so the block backs up into the pixel input
	always begin
		@(hold_off_start);
		@(negedge clk);
		sink_held = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(negedge clk);
		sink_held = 1'b0;
	end

	// ---------------------------------------------------------------
	// Driver tasks. Each returns in the time step of its last edge,
	// with nothing scheduled, so the next task may drive at once.
	// ---------------------------------------------------------------
	task automatic send_pixel(input logic [7:0] px);
		int gap_pct;
		gap_pct = (flow == FLOW_SRC_GAPS) ? 51 : (flow == FLOW_BOTH) ? 7 : 0;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_frame(input int w, input int h, input pix_style_t style,
			input logic [7:0] body, input logic [7:0] last_col, input int table_count);
		int r, c, base;
		logic [7:0] px;
		table_counts.push_back(table_count);
		base = $urandom_range(240);
		for (r = 0; r < h; r++) begin
			for (c = 0; c < w; c++) begin
				case (style)
					PIX_TABLE:  px = (c == w - 1) ? last_col : body;
					PIX_SMOOTH: px = 8'(base + $urandom_range(15));
					PIX_BINARY: px = $urandom_range(1) ? 8'hFF : 8'h00;
					default:    px = 8'($urandom_range(255));
				endcase
				send_pixel(px);
			end
		end
	endtask

	// block idle: every owed count back, then the pipe's latency and a margin
	task automatic await_idle();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (frame_counts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [sec_pkg::REG_IDX_W-1:0] idx,
			input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// read back one register; prdata taken at the edge closing the access phase
	task automatic check_reg(input logic [sec_pkg::REG_IDX_W-1:0] idx,
			input logic [31:0] expv);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== expv)
			flag_mismatch("register readback", expv, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] w, input logic [31:0] h,
			input logic [31:0] thr);
		await_idle();
		reg_write(sec_pkg::REG_IMAGE_WIDTH, w);
		reg_write(sec_pkg::REG_IMAGE_HEIGHT, h);
		reg_write(sec_pkg::REG_EDGE_THRESHOLD, thr);
		check_reg(sec_pkg::REG_IMAGE_WIDTH, w & 32'h7FF);
		check_reg(sec_pkg::REG_IMAGE_HEIGHT, h & 32'h1FFF);
		check_reg(sec_pkg::REG_EDGE_THRESHOLD, thr & 32'hFF);
	endtask

	// ---------------------------------------------------------------
	// Main sequence: reset, register defaults, directed table, random
	// phases over all flow modes, a back-pressure phase, register extremes.
	// ---------------------------------------------------------------
	frame_row_t frame_rows [3];

	initial begin
		int i, k, phase, pixels_done, n_frames, w_cfg, h_cfg, thr_cfg, w, h;

		// 3x3 frames. Sizes below 3 clamp up. Threshold zero: the lone interior
		// pixel counts. Full-scale step in the last column saturates to exactly
		// the top threshold. Flat white never reaches a threshold of one.
		frame_rows[0] = '{11'd0, 13'd0, 8'd0,   8'h00, 8'h00, 1};
		frame_rows[1] = '{11'd1, 13'd2, 8'd255, 8'h00, 8'hFF, 1};
		frame_rows[2] = '{11'd3, 13'd3, 8'd1,   8'hFF, 8'hFF, 0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reg(sec_pkg::REG_IMAGE_WIDTH, 32'd640);
		check_reg(sec_pkg::REG_IMAGE_HEIGHT, 32'd480);
		check_reg(sec_pkg::REG_EDGE_THRESHOLD, 32'd70);

		for (i = 0; i < 3; i++) begin
			configure(frame_rows[i].width, frame_rows[i].height, frame_rows[i].thr);
			send_frame(clamp_dim(int'(frame_rows[i].width), LINE_MAX),
				clamp_dim(int'(frame_rows[i].height), ROWS_MAX), PIX_TABLE,
				frame_rows[i].body, frame_rows[i].last_col, frame_rows[i].count);
		end

		// random phases: mostly small frames so counts come often
		phase = 0;
		pixels_done = 0;
		while (pixels_done < RANDOM_PIXELS) begin
			case ($urandom_range(9))
				0:       w_cfg = $urandom_range(2);
				1:       w_cfg = $urandom_range(9, 20);
				default: w_cfg = $urandom_range(3, 8);
			endcase
			case ($urandom_range(9))
				0:       h_cfg = $urandom_range(2);
				1:       h_cfg = $urandom_range(9, 12);
				default: h_cfg = $urandom_range(3, 8);
			endcase
			case ($urandom_range(5))
				0:       thr_cfg = 0;
				1:       thr_cfg = 255;
				default: thr_cfg = $urandom_range(255);
			endcase
			flow = flow_t'(phase % 4);
			configure(w_cfg, h_cfg, thr_cfg);
			w = clamp_dim(w_cfg, LINE_MAX);
			h = clamp_dim(h_cfg, ROWS_MAX);
			n_frames = $urandom_range(2, 4);
			for (k = 0; k < n_frames && pixels_done < RANDOM_PIXELS; k++) begin
				send_frame(w, h, pix_style_t'($urandom_range(PIX_NOISE, PIX_BINARY)),
					8'h00, 8'h00, NO_TABLE_COUNT);
				pixels_done += w * h;
			end
			phase++;
		end

		// receiver holds off while 3x3 frames keep coming: result register fills,
		// input stalls, then everything drains
		flow = FLOW_STEADY;
		configure(3, 3, $urandom_range(255));
		-> hold_off_start;
		for (k = 0; k < 12; k++)
			send_frame(3, 3, PIX_NOISE, 8'h00, 8'h00, NO_TABLE_COUNT);

		// register extremes: all ones written, each register keeps its own width
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		await_idle();
		if (mismatch_total == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// hang guard, many times the slowest correct run
	initial begin
		#(RUN_LIMIT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
